// ----- hw/rtl/rmj_pkg.sv -----
package rmj_pkg;

	localparam int DataW = 32;
	localparam int FracW = 16;
	localparam int CfgW = 17;
	localparam logic [CfgW-1:0] MinRangeSqReset = 17'd7;

	localparam int SqW = 2 * DataW;
	localparam int RootW = DataW;
	localparam int SqRemW = RootW + 3;
	localparam int CW = 2 * DataW;
	localparam int DenW = SqW + RootW;
	localparam int QW = DataW;
	localparam int NumW = DenW + QW;
	localparam int NLanes = 6;
	localparam int SqrtCells = RootW;
	localparam int DivCells = QW;

	localparam int LnRangeX = 0;
	localparam int LnRangeY = 1;
	localparam int LnBearX = 2;
	localparam int LnBearY = 3;
	localparam int LnRateX = 4;
	localparam int LnRateY = 5;

	typedef struct packed {
		logic inv;
		logic [SqW-1:0] s;
		logic [SqW-1:0] sh;
		logic [SqRemW-1:0] rem;
		logic [RootW-1:0] root;
		logic [DataW-1:0] px;
		logic [DataW-1:0] py;
		logic [CW-1:0] cm;
		logic nx;
		logic ny;
		logic nc;
	} sq_t;

	typedef struct packed {
		logic neg;
		logic ov;
		logic [DenW-1:0] den;
		logic [DenW-1:0] rem;
		logic [QW-1:0] lo;
		logic [QW-1:0] q;
	} lane_t;

	typedef struct packed {
		logic inv;
		lane_t [NLanes-1:0] lane;
	} dv_t;

	typedef struct packed {
		logic inv;
		logic [NLanes-1:0][DataW-1:0] e;
	} res_t;

endpackage

// ----- hw/rtl/rmj_prep.sv -----
module rmj_prep (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic item_v,
	input  logic signed [rmj_pkg::DataW-1:0] pos_x,
	input  logic signed [rmj_pkg::DataW-1:0] pos_y,
	input  logic signed [rmj_pkg::DataW-1:0] vel_x,
	input  logic signed [rmj_pkg::DataW-1:0] vel_y,
	input  logic [rmj_pkg::CfgW-1:0] min_range_squared,
	output logic this_v,
	output rmj_pkg::sq_t this_stage
);
	import rmj_pkg::*;

	logic v_s1, v_s2;
	logic [DataW-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic nx_s1, ny_s1, nvx_s1, nvy_s1;
	logic [SqW-1:0] pxx_s2, pyy_s2, vxpy_s2, vypx_s2;
	logic [DataW-1:0] px_s2, py_s2;
	logic nx_s2, ny_s2, sa_s2, sb_s2;
	logic [SqW-1:0] s_sum;
	logic [CW:0] diff, sum;
	logic [CW:0] mag;
	logic nc;
	logic inv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			this_v <= 1'b0;
		end else if (en) begin
			v_s1 <= item_v;
			v_s2 <= v_s1;
			this_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= pos_x[DataW-1] ? -pos_x : pos_x;
			py_s1 <= pos_y[DataW-1] ? -pos_y : pos_y;
			vx_s1 <= vel_x[DataW-1] ? -vel_x : vel_x;
			vy_s1 <= vel_y[DataW-1] ? -vel_y : vel_y;
			nx_s1 <= pos_x[DataW-1];
			ny_s1 <= pos_y[DataW-1];
			nvx_s1 <= vel_x[DataW-1];
			nvy_s1 <= vel_y[DataW-1];

			pxx_s2 <= px_s1 * px_s1;
			pyy_s2 <= py_s1 * py_s1;
			vxpy_s2 <= vx_s1 * py_s1;
			vypx_s2 <= vy_s1 * px_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			sa_s2 <= nvx_s1 ^ ny_s1;
			sb_s2 <= nvy_s1 ^ nx_s1;

			this_stage.inv <= inv;
			this_stage.s <= s_sum;
			this_stage.sh <= s_sum;
			this_stage.rem <= '0;
			this_stage.root <= '0;
			this_stage.px <= px_s2;
			this_stage.py <= py_s2;
			this_stage.cm <= mag[CW-1:0];
			this_stage.nx <= nx_s2;
			this_stage.ny <= ny_s2;
			this_stage.nc <= nc;
		end
	end

	always_comb begin
		s_sum = pxx_s2 + pyy_s2;
		diff = {1'b0, vxpy_s2} - {1'b0, vypx_s2};
		sum = {1'b0, vxpy_s2} + {1'b0, vypx_s2};
		if (sa_s2 == sb_s2) begin
			mag = diff[CW] ? -diff : diff;
			nc = (diff != '0) && (sa_s2 ^ diff[CW]);
		end else begin
			mag = sum;
			nc = sa_s2 && (sum != '0);
		end
		inv = (s_sum < SqW'({min_range_squared, {FracW{1'b0}}})) || (s_sum == '0);
	end

endmodule

// ----- hw/rtl/rmj_sqrt_cell.sv -----
module rmj_sqrt_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic prev_v,
	input  rmj_pkg::sq_t prev_stage,
	output logic this_v,
	output rmj_pkg::sq_t this_stage
);
	import rmj_pkg::*;

	logic [SqRemW-1:0] rem2, trial;
	logic ge;
	sq_t nxt;

	always_comb begin
		rem2 = {prev_stage.rem[SqRemW-3:0], prev_stage.sh[SqW-1 -: 2]};
		trial = SqRemW'({prev_stage.root, 2'b01});
		ge = rem2 >= trial;
		nxt = prev_stage;
		nxt.rem = ge ? rem2 - trial : rem2;
		nxt.root = {prev_stage.root[RootW-2:0], ge};
		nxt.sh = {prev_stage.sh[SqW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			this_v <= 1'b0;
		end else if (en) begin
			this_v <= prev_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			this_stage <= nxt;
		end
	end

endmodule

// ----- hw/rtl/rmj_mid.sv -----
module rmj_mid (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic prev_v,
	input  rmj_pkg::sq_t prev_stage,
	output logic this_v,
	output rmj_pkg::dv_t this_stage
);
	import rmj_pkg::*;

	logic v_s1, v_s2;
	logic [2*DataW-1:0] sr_lo_s1, sr_hi_s1, cy_lo_s1, cy_hi_s1, cx_lo_s1, cx_hi_s1;
	logic [SqW-1:0] s_s1, s_s2;
	logic [RootW-1:0] root_s1, root_s2;
	logic [DataW-1:0] px_s1, py_s1, px_s2, py_s2;
	logic nx_s1, ny_s1, nc_s1, inv_s1;
	logic nx_s2, ny_s2, nc_s2, inv_s2;
	logic [DenW-1:0] sr_s2, ny4_s2, nx5_s2;
	logic [NLanes-1:0][NumW-1:0] num;
	logic [NLanes-1:0][DenW-1:0] den;
	logic [NLanes-1:0] neg;
	dv_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			this_v <= 1'b0;
		end else if (en) begin
			v_s1 <= prev_v;
			v_s2 <= v_s1;
			this_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_lo_s1 <= prev_stage.s[DataW-1:0] * prev_stage.root;
			sr_hi_s1 <= prev_stage.s[SqW-1:DataW] * prev_stage.root;
			cy_lo_s1 <= prev_stage.cm[DataW-1:0] * prev_stage.py;
			cy_hi_s1 <= prev_stage.cm[CW-1:DataW] * prev_stage.py;
			cx_lo_s1 <= prev_stage.cm[DataW-1:0] * prev_stage.px;
			cx_hi_s1 <= prev_stage.cm[CW-1:DataW] * prev_stage.px;
			s_s1 <= prev_stage.s;
			root_s1 <= prev_stage.root;
			px_s1 <= prev_stage.px;
			py_s1 <= prev_stage.py;
			nx_s1 <= prev_stage.nx;
			ny_s1 <= prev_stage.ny;
			nc_s1 <= prev_stage.nc;
			inv_s1 <= prev_stage.inv;

			sr_s2 <= {sr_hi_s1, {QW{1'b0}}} + DenW'(sr_lo_s1);
			ny4_s2 <= {cy_hi_s1, {QW{1'b0}}} + DenW'(cy_lo_s1);
			nx5_s2 <= {cx_hi_s1, {QW{1'b0}}} + DenW'(cx_lo_s1);
			s_s2 <= s_s1;
			root_s2 <= root_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			nc_s2 <= nc_s1;
			inv_s2 <= inv_s1;

			this_stage <= nxt;
		end
	end

	always_comb begin
		num[LnRangeX] = NumW'({px_s2, {FracW{1'b0}}});
		num[LnRangeY] = NumW'({py_s2, {FracW{1'b0}}});
		num[LnBearX] = NumW'({py_s2, {(2*FracW){1'b0}}});
		num[LnBearY] = NumW'({px_s2, {(2*FracW){1'b0}}});
		num[LnRateX] = NumW'({ny4_s2, {FracW{1'b0}}});
		num[LnRateY] = NumW'({nx5_s2, {FracW{1'b0}}});
		den[LnRangeX] = DenW'(root_s2);
		den[LnRangeY] = DenW'(root_s2);
		den[LnBearX] = DenW'(s_s2);
		den[LnBearY] = DenW'(s_s2);
		den[LnRateX] = sr_s2;
		den[LnRateY] = sr_s2;
		neg[LnRangeX] = nx_s2;
		neg[LnRangeY] = ny_s2;
		neg[LnBearX] = !ny_s2;
		neg[LnBearY] = nx_s2;
		neg[LnRateX] = ny_s2 ^ nc_s2;
		neg[LnRateY] = nx_s2 == nc_s2;
		nxt.inv = inv_s2;
		for (int k = 0; k < NLanes; k++) begin
			nxt.lane[k].neg = neg[k];
			nxt.lane[k].ov = num[k] >= {den[k], {QW{1'b0}}};
			nxt.lane[k].den = den[k];
			nxt.lane[k].rem = num[k][NumW-1:QW];
			nxt.lane[k].lo = num[k][QW-1:0];
			nxt.lane[k].q = '0;
		end
	end

endmodule

// ----- hw/rtl/rmj_div_cell.sv -----
module rmj_div_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic prev_v,
	input  rmj_pkg::dv_t prev_stage,
	output logic this_v,
	output rmj_pkg::dv_t this_stage
);
	import rmj_pkg::*;

	logic [NLanes-1:0][DenW:0] rem2, rem3;
	logic [NLanes-1:0] ge;
	dv_t nxt;

	always_comb begin
		nxt = prev_stage;
		for (int k = 0; k < NLanes; k++) begin
			rem2[k] = {prev_stage.lane[k].rem, prev_stage.lane[k].lo[QW-1]};
			ge[k] = rem2[k] >= {1'b0, prev_stage.lane[k].den};
			rem3[k] = ge[k] ? rem2[k] - {1'b0, prev_stage.lane[k].den} : rem2[k];
			nxt.lane[k].rem = rem3[k][DenW-1:0];
			nxt.lane[k].lo = {prev_stage.lane[k].lo[QW-2:0], 1'b0};
			nxt.lane[k].q = {prev_stage.lane[k].q[QW-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			this_v <= 1'b0;
		end else if (en) begin
			this_v <= prev_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			this_stage <= nxt;
		end
	end

endmodule

// ----- hw/rtl/radar_measurement_jacobian_top.sv -----
// Stages from input transaction to result on out_valid: 3 prep stages, 32 square-root
// cells, 3 multiply stages, 32 divider cells, output reg. A two-entry output register
// absorbs a stall; one transaction per cycle is taken while in_ready is high.
// Reset: arst_n clears all valid bits and loads min_range_squared with 7; no clearing pass.
module radar_measurement_jacobian_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [rmj_pkg::CfgW-1:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [rmj_pkg::DataW-1:0] pos_x,
	input  logic signed [rmj_pkg::DataW-1:0] pos_y,
	input  logic signed [rmj_pkg::DataW-1:0] vel_x,
	input  logic signed [rmj_pkg::DataW-1:0] vel_y,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [rmj_pkg::DataW-1:0] d_range_d_px,
	output logic signed [rmj_pkg::DataW-1:0] d_range_d_py,
	output logic signed [rmj_pkg::DataW-1:0] d_bearing_d_px,
	output logic signed [rmj_pkg::DataW-1:0] d_bearing_d_py,
	output logic signed [rmj_pkg::DataW-1:0] d_rate_d_px,
	output logic signed [rmj_pkg::DataW-1:0] d_rate_d_py,
	output logic signed [rmj_pkg::DataW-1:0] d_rate_d_vx,
	output logic signed [rmj_pkg::DataW-1:0] d_rate_d_vy,
	output logic invalid
);
	import rmj_pkg::*;

	logic [CfgW-1:0] min_range_squared_q;
	logic en;
	logic sq_v [0:SqrtCells];
	sq_t sq_chain [0:SqrtCells];
	logic dv_v [0:DivCells];
	dv_t dv_chain [0:DivCells];
	res_t res, out_q, skid_q;
	logic out_v_q, skid_v_q;
	logic push;

	function automatic logic [DataW-1:0] sat_q(lane_t l);
		logic [DataW-1:0] maxpos;
		logic [DataW-1:0] minneg;
		maxpos = {1'b0, {(DataW-1){1'b1}}};
		minneg = {1'b1, {(DataW-1){1'b0}}};
		if (l.ov) begin
			return l.neg ? minneg : maxpos;
		end
		if (l.neg) begin
			return (l.q > minneg) ? minneg : -l.q;
		end
		return (l.q > maxpos) ? maxpos : l.q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_squared_q <= MinRangeSqReset;
		end else if (cfg_wr_en) begin
			min_range_squared_q <= cfg_wr_data;
		end
	end

	assign en = !skid_v_q;
	assign in_ready = en;

	rmj_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.item_v(in_valid),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.min_range_squared(min_range_squared_q),
		.this_v(sq_v[0]),
		.this_stage(sq_chain[0])
	);

	for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
		rmj_sqrt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev_v(sq_v[i]),
			.prev_stage(sq_chain[i]),
			.this_v(sq_v[i+1]),
			.this_stage(sq_chain[i+1])
		);
	end

	rmj_mid u_mid (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.prev_v(sq_v[SqrtCells]),
		.prev_stage(sq_chain[SqrtCells]),
		.this_v(dv_v[0]),
		.this_stage(dv_chain[0])
	);

	for (genvar i = 0; i < DivCells; i++) begin : g_div
		rmj_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev_v(dv_v[i]),
			.prev_stage(dv_chain[i]),
			.this_v(dv_v[i+1]),
			.this_stage(dv_chain[i+1])
		);
	end

	always_comb begin
		res.inv = dv_chain[DivCells].inv;
		for (int k = 0; k < NLanes; k++) begin
			res.e[k] = dv_chain[DivCells].inv ? '0 : sat_q(dv_chain[DivCells].lane[k]);
		end
	end

	assign push = en && dv_v[DivCells];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !out_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_v_q;
	assign invalid = out_q.inv;
	assign d_range_d_px = out_q.e[LnRangeX];
	assign d_range_d_py = out_q.e[LnRangeY];
	assign d_bearing_d_px = out_q.e[LnBearX];
	assign d_bearing_d_py = out_q.e[LnBearY];
	assign d_rate_d_px = out_q.e[LnRateX];
	assign d_rate_d_py = out_q.e[LnRateY];
	assign d_rate_d_vx = out_q.e[LnRangeX];
	assign d_rate_d_vy = out_q.e[LnRangeY];

	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid entry held without a valid output entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.inv |-> out_q.e == '0)
		else $error("invalid transaction with nonzero entries");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && out_v_q && !out_ready |=> skid_v_q)
		else $error("result lost while output stalled");

endmodule

// ----- tb/sv/radar_measurement_jacobian_top_tb.sv -----
`timescale 1ns / 100ps

module radar_measurement_jacobian_top_tb;
	import rmj_pkg::*;

	typedef struct {
		logic [DataW-1:0] rng_px;
		logic [DataW-1:0] rng_py;
		logic [DataW-1:0] brg_px;
		logic [DataW-1:0] brg_py;
		logic [DataW-1:0] rate_px;
		logic [DataW-1:0] rate_py;
		logic [DataW-1:0] rate_vx;
		logic [DataW-1:0] rate_vy;
		logic inv;
	} jacobian_t;

	localparam logic [DataW-1:0] MaxPos = 32'h7fff_ffff;
	localparam logic [DataW-1:0] MinNeg = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CfgW-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DataW-1:0] pos_x = '0;
	logic signed [DataW-1:0] pos_y = '0;
	logic signed [DataW-1:0] vel_x = '0;
	logic signed [DataW-1:0] vel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DataW-1:0] d_range_d_px, d_range_d_py, d_bearing_d_px, d_bearing_d_py;
	logic signed [DataW-1:0] d_rate_d_px, d_rate_d_py, d_rate_d_vx, d_rate_d_vy;
	logic invalid;

	jacobian_t jacobian_q[$];
	logic [CfgW-1:0] min_range_sq = MinRangeSqReset;
	int send_idle = 11;
	int recv_idle = 53;
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int invalid_seen = 0;

	radar_measurement_jacobian_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.d_range_d_px(d_range_d_px), .d_range_d_py(d_range_d_py),
		.d_bearing_d_px(d_bearing_d_px), .d_bearing_d_py(d_bearing_d_py),
		.d_rate_d_px(d_rate_d_px), .d_rate_d_py(d_rate_d_py),
		.d_rate_d_vx(d_rate_d_vx), .d_rate_d_vy(d_rate_d_vy),
		.invalid(invalid)
	);

	always #5 clk = ~clk;

	function automatic logic [DataW-1:0] sat_quot(input bit neg, input logic [127:0] num,
			input logic [127:0] den);
		logic [127:0] q;
		q = num / den;
		if (!neg) begin
			return (q > 128'(MaxPos)) ? MaxPos : q[DataW-1:0];
		end
		return (q > 128'(MinNeg)) ? MinNeg : -q[DataW-1:0];
	endfunction

	function automatic logic [63:0] range_root(input logic [63:0] s);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			cand = res | (64'd1 << i);
			if (cand * cand <= s) res = cand;
		end
		return res;
	endfunction

	function automatic jacobian_t predict_jacobian(input logic [DataW-1:0] px,
			input logic [DataW-1:0] py, input logic [DataW-1:0] vx, input logic [DataW-1:0] vy);
		jacobian_t j;
		bit nx, ny, nvx, nvy, nc;
		logic [DataW-1:0] mx, my, mvx, mvy;
		logic [63:0] s, r;
		logic [127:0] t1, t2, c, cm, sr;
		nx = px[DataW-1]; ny = py[DataW-1]; nvx = vx[DataW-1]; nvy = vy[DataW-1];
		mx = nx ? -px : px;
		my = ny ? -py : py;
		mvx = nvx ? -vx : vx;
		mvy = nvy ? -vy : vy;
		s = 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
		j = '{default: '0};
		if (s == 0 || s < (64'(min_range_sq) << FracW)) begin
			j.inv = 1'b1;
			return j;
		end
		r = range_root(s);
		t1 = 128'(mvx) * 128'(my);
		if (nvx != ny) t1 = -t1;
		t2 = 128'(mvy) * 128'(mx);
		if (nvy != nx) t2 = -t2;
		c = t1 - t2;
		nc = c[127];
		cm = nc ? -c : c;
		sr = 128'(s) * 128'(r);
		j.rng_px = sat_quot(nx, 128'(mx) << FracW, 128'(r));
		j.rng_py = sat_quot(ny, 128'(my) << FracW, 128'(r));
		j.brg_px = sat_quot(!ny, 128'(my) << (2 * FracW), 128'(s));
		j.brg_py = sat_quot(nx, 128'(mx) << (2 * FracW), 128'(s));
		j.rate_px = sat_quot(ny != nc, (cm * 128'(my)) << FracW, sr);
		j.rate_py = sat_quot(nx == nc, (cm * 128'(mx)) << FracW, sr);
		j.rate_vx = j.rng_px;
		j.rate_vy = j.rng_py;
		return j;
	endfunction

	task automatic check_field(input string name, input logic [DataW-1:0] exp_v,
			input logic [DataW-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		jacobian_t e;
		if (arst_n && out_valid && out_ready) begin
			if (jacobian_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
			end else begin
				e = jacobian_q.pop_front();
				check_field("d_range_d_px", e.rng_px, d_range_d_px);
				check_field("d_range_d_py", e.rng_py, d_range_d_py);
				check_field("d_bearing_d_px", e.brg_px, d_bearing_d_px);
				check_field("d_bearing_d_py", e.brg_py, d_bearing_d_py);
				check_field("d_rate_d_px", e.rate_px, d_rate_d_px);
				check_field("d_rate_d_py", e.rate_py, d_rate_d_py);
				check_field("d_rate_d_vx", e.rate_vx, d_rate_d_vx);
				check_field("d_rate_d_vy", e.rate_vy, d_rate_d_vy);
				check_field("invalid", 32'(e.inv), 32'(invalid));
				checked++;
				if (e.inv) invalid_seen++;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic send_state(input logic [DataW-1:0] px, input logic [DataW-1:0] py,
			input logic [DataW-1:0] vx, input logic [DataW-1:0] vy);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		vel_x <= vx;
		vel_y <= vy;
		do @(posedge clk); while (!in_ready);
		jacobian_q.push_back(predict_jacobian(px, py, vx, vy));
		sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (jacobian_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_min_range(input logic [CfgW-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		min_range_sq = v;
	endtask

	function automatic logic [DataW-1:0] rand_field();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(4096)) - 2048);
			2: return 32'($signed($urandom_range(2097152)) - 1048576);
			3: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
			4: return $urandom_range(1) ? MaxPos - $urandom_range(3) : MinNeg + $urandom_range(3);
			default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
		endcase
	endfunction

	task automatic test_directed;
		send_state(0, 0, 0, 0);
		send_state(MaxPos, MaxPos, MaxPos, MaxPos);
		send_state(MinNeg, MinNeg, MinNeg, MinNeg);
		send_state(MaxPos, MinNeg, MinNeg, MaxPos);
		send_state(MinNeg, 0, 32'h0001_0000, MaxPos);
		send_state(0, MinNeg, MaxPos, 0);
		send_state(32'd677, 0, 32'h0001_0000, 0);
		send_state(32'd678, 0, 32'h0001_0000, 0);
		send_state(0, -32'sd678, 0, 32'h0001_0000);
		send_state(32'h0001_0000, 32'h0001_0000, -32'sh0002_0000, 32'h0003_0000);
		send_state(-32'sh0003_0000, 32'h0004_0000, 32'h0001_8000, -32'sh0000_4000);
		send_state(32'h0000_1000, 32'hffff_f000, MaxPos, MinNeg);
	endtask

	task automatic test_zero_threshold;
		set_min_range(0);
		send_state(0, 0, MaxPos, MinNeg);
		send_state(1, 0, 0, 0);
		send_state(0, 32'hffff_ffff, MaxPos, MaxPos);
		send_state(1, 1, MinNeg, MaxPos);
		send_state(32'd3, -32'sd2, 32'h7000_0000, -32'sh7000_0000);
	endtask

	task automatic test_max_threshold;
		set_min_range(17'h1_0000);
		send_state(32'h00ff_ffff, 0, 32'h0001_0000, 0);
		send_state(32'h0100_0000, 0, 32'h0001_0000, 0);
		send_state(0, 32'hff00_0000, 0, 32'h0001_0000);
		send_state(MinNeg, MaxPos, 0, 0);
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			send_state(rand_field(), rand_field(), rand_field(), rand_field());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 11;
		recv_idle = 53;
		test_directed();
		test_zero_threshold();
		test_max_threshold();
		set_min_range(17'($urandom_range(32'h1_0000)));
		test_random(200);
		set_min_range(MinRangeSqReset);
		test_random(200);
		send_idle = 53;
		recv_idle = 11;
		set_min_range(17'h1_ffff);
		test_random(200);
		set_min_range(17'($urandom_range(64)));
		test_random(200);
		send_idle = 0;
		recv_idle = 0;
		set_min_range(0);
		test_random(200);
		set_min_range(17'h1_0000);
		test_random(200);
		drain();
		$display("sent %0d states, checked %0d results (%0d invalid)", sent, checked,
			invalid_seen);
		$display("thresholds from zero to full scale, three idle patterns");
		if (errors == 0) begin
			$display("radar_measurement_jacobian_top_tb: done, clean");
		end else begin
			$display("radar_measurement_jacobian_top_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout, %0d results still pending", jacobian_q.size());
		$display("radar_measurement_jacobian_top_tb: done, errors");
		$finish;
	end

endmodule
